// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, constants and helpers for the scaled decimal compare pipeline.
// ----------------------------------------------------------------------------
package sdc_pkg;

    // word field widths
    localparam int FUNC_W  = 3;
    localparam int SCALE_W = 5;
    localparam int MANT_W  = 96;

    // wide magnitude, kept as limbs for the scaling multipliers
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = 8;
    localparam int MAG_W   = LIMBS * LIMB_W;
    localparam int HI_TOP  = 8 * 32 - 32 - 1;

    // each scaling step multiplies by at most 10^9, which fits one limb
    localparam int MAX_STEP_EXP = 9;
    localparam int STEP_EXP_W   = 4;

    // parameter defaults
    localparam int DEF_MANT_BITS = 96;
    localparam int DEF_MAX_SCALE = 28;

    // comparison selector
    typedef enum logic [FUNC_W-1:0] {
        FUNC_EQ = 3'd0,
        FUNC_NE = 3'd1,
        FUNC_LT = 3'd2,
        FUNC_LE = 3'd3,
        FUNC_GT = 3'd4,
        FUNC_GE = 3'd5
    } func_t;

    // control that rides along with the magnitudes
    typedef struct packed {
        func_t func;
        logic  swap;    // x holds operand b, y holds operand a
        logic  a_neg;
        logic  b_neg;
    } ctl_t;

    // one word in flight between stages
    typedef struct packed {
        ctl_t               ctl;
        logic [SCALE_W-1:0] rem;    // powers of ten still to apply to x
        logic [MAG_W-1:0]   x_mag;  // operand with the smaller scale, being scaled
        logic [MANT_W-1:0]  y_mag;  // operand with the larger scale, untouched
    } item_t;

    // small power-of-ten table, one limb wide
    function automatic logic [LIMB_W-1:0] pow10(input logic [STEP_EXP_W-1:0] e);
        logic [LIMB_W-1:0] p;
        unique case (e)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/scaled_decimal_compare.sv =====
// ----------------------------------------------------------------------------
// scaled_decimal_compare
// Compares two signed scaled decimal numbers and reports one relation bit.
// ----------------------------------------------------------------------------
// A pair of numbers enters every cycle while out_ready does not hold up the
// pipeline. A pair passes the decode register, then STEPS = ceil(MAX_SCALE/9)
// scaling steps, then the compare register. The scale alignment applies
// 10^difference to the operand with the smaller scale in steps of up to 10^9,
// each step a bank of 32x32 limb multipliers followed by a 256-bit adder,
// each in its own register stage. Every stage holds its word independently,
// so while a result waits on out_ready the stages behind it keep filling.
// ----------------------------------------------------------------------------
module scaled_decimal_compare
    import sdc_pkg::*;
#(
    parameter int MANT_BITS = DEF_MANT_BITS,
    parameter int MAX_SCALE = DEF_MAX_SCALE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [63:0]        a_mant_low,
    input  logic [31:0]        a_mant_high,
    input  logic [SCALE_W-1:0] a_scale,
    input  logic               a_negative,
    input  logic [63:0]        b_mant_low,
    input  logic [31:0]        b_mant_high,
    input  logic [SCALE_W-1:0] b_scale,
    input  logic               b_negative,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               holds
);

    localparam int STEPS = (MAX_SCALE + MAX_STEP_EXP - 1) / MAX_STEP_EXP;

    logic  step_valid [STEPS+1];
    logic  step_ready [STEPS+1];
    item_t step_item  [STEPS+1];

    // decode and operand routing
    sdc_decode #(
        .MANT_BITS (MANT_BITS),
        .MAX_SCALE (MAX_SCALE)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .a_mant_low  (a_mant_low),
        .a_mant_high (a_mant_high),
        .a_scale     (a_scale),
        .a_negative  (a_negative),
        .b_mant_low  (b_mant_low),
        .b_mant_high (b_mant_high),
        .b_scale     (b_scale),
        .b_negative  (b_negative),
        .out_valid   (step_valid[0]),
        .out_ready   (step_ready[0]),
        .out_item    (step_item[0])
    );

    // scale alignment chain
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        sdc_scale_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[s]),
            .in_ready  (step_ready[s]),
            .in_item   (step_item[s]),
            .out_valid (step_valid[s+1]),
            .out_ready (step_ready[s+1]),
            .out_item  (step_item[s+1])
        );
    end

    // compare and relation select
    sdc_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid[STEPS]),
        .in_ready  (step_ready[STEPS]),
        .in_item   (step_item[STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .holds     (holds)
    );

    // the alignment exponent is fully used up by the end of the chain
    a_rem_spent: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid[STEPS] |-> (step_item[STEPS].rem == '0))
        else $error("scale difference not fully applied");

    // decoded scale difference never exceeds the scale range
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid[0] |-> (step_item[0].rem <= SCALE_W'(MAX_SCALE)))
        else $error("scale difference out of range");

    // input back-pressure only when the output is held up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // a word stalled at the compare stage input is still there next cycle
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid[STEPS] && !step_ready[STEPS]) |=> step_valid[STEPS])
        else $error("word lost at compare stage input");

endmodule

// ===== src/sdc_decode.sv =====
// ----------------------------------------------------------------------------
// sdc_decode
// Input stage: masks mantissas, clamps scales and routes the operand with the
// smaller scale onto the scaling path.
// ----------------------------------------------------------------------------
module sdc_decode
    import sdc_pkg::*;
#(
    parameter int MANT_BITS = DEF_MANT_BITS,
    parameter int MAX_SCALE = DEF_MAX_SCALE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [63:0]        a_mant_low,
    input  logic [31:0]        a_mant_high,
    input  logic [SCALE_W-1:0] a_scale,
    input  logic               a_negative,
    input  logic [63:0]        b_mant_low,
    input  logic [31:0]        b_mant_high,
    input  logic [SCALE_W-1:0] b_scale,
    input  logic               b_negative,
    output logic               out_valid,
    input  logic               out_ready,
    output item_t              out_item
);

    localparam logic [MANT_W-1:0]  MANT_MASK = {MANT_W{1'b1}} >> (MANT_W - MANT_BITS);
    localparam logic [SCALE_W-1:0] SCALE_TOP = SCALE_W'(MAX_SCALE);

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [MANT_W-1:0]  a_mant;
    logic [MANT_W-1:0]  b_mant;
    logic [SCALE_W-1:0] a_sc;
    logic [SCALE_W-1:0] b_sc;

    // mask mantissas and saturate scales
    always_comb
    begin
        a_mant = {a_mant_high, a_mant_low} & MANT_MASK;
        b_mant = {b_mant_high, b_mant_low} & MANT_MASK;
        a_sc   = (a_scale > SCALE_TOP) ? SCALE_TOP : a_scale;
        b_sc   = (b_scale > SCALE_TOP) ? SCALE_TOP : b_scale;
    end

    // smaller scale goes to x, difference becomes the exponent to apply
    always_comb
    begin
        item_next           = '0;
        item_next.ctl.func  = func_t'(func);
        item_next.ctl.a_neg = a_negative;
        item_next.ctl.b_neg = b_negative;
        if (a_sc <= b_sc)
        begin
            item_next.ctl.swap = 1'b0;
            item_next.rem      = b_sc - a_sc;
            item_next.x_mag    = MAG_W'(a_mant);
            item_next.y_mag    = b_mant;
        end
        else
        begin
            item_next.ctl.swap = 1'b1;
            item_next.rem      = a_sc - b_sc;
            item_next.x_mag    = MAG_W'(b_mant);
            item_next.y_mag    = a_mant;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== src/sdc_scale_step.sv =====
// ----------------------------------------------------------------------------
// sdc_scale_step
// One scaling step: multiplies x by up to 10^9 in two stages, limb products
// first, then the carry-propagating sum of the shifted product halves.
// ----------------------------------------------------------------------------
module sdc_scale_step
    import sdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic [STEP_EXP_W-1:0] exp_step;
    logic [LIMB_W-1:0]     factor;
    logic [MAG_W-1:0]      lo_next;
    logic [MAG_W-1:0]      hi_next;
    logic [2*LIMB_W-1:0]   prod;

    logic                  mul_valid_reg;
    ctl_t                  mul_ctl_reg;
    logic [SCALE_W-1:0]    mul_rem_reg;
    logic [MAG_W-1:0]      mul_lo_reg;
    logic [MAG_W-1:0]      mul_hi_reg;
    logic [MANT_W-1:0]     mul_y_reg;
    logic                  mul_ready;

    logic                  sum_valid_reg;
    item_t                 sum_item_reg;
    item_t                 sum_item_next;
    logic                  sum_ready;

    // exponent for this step and its factor
    always_comb
    begin
        if (in_item.rem > SCALE_W'(MAX_STEP_EXP))
        begin
            exp_step = STEP_EXP_W'(MAX_STEP_EXP);
        end
        else
        begin
            exp_step = in_item.rem[STEP_EXP_W-1:0];
        end
        factor = pow10(exp_step);
    end

    // one 32x32 product per limb, split into low and high halves
    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        prod    = '0;
        for (int i = 0; i < LIMBS; i++)
        begin
            prod = in_item.x_mag[i*LIMB_W +: LIMB_W] * factor;
            lo_next[i*LIMB_W +: LIMB_W] = prod[LIMB_W-1:0];
            hi_next[i*LIMB_W +: LIMB_W] = prod[2*LIMB_W-1:LIMB_W];
        end
    end

    assign sum_ready = !sum_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || sum_ready;
    assign in_ready  = mul_ready;

    // product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (mul_ready)
        begin
            mul_valid_reg <= in_valid;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && mul_ready)
        begin
            mul_ctl_reg <= in_item.ctl;
            mul_rem_reg <= in_item.rem - SCALE_W'(exp_step);
            mul_lo_reg  <= lo_next;
            mul_hi_reg  <= hi_next;
            mul_y_reg   <= in_item.y_mag;
        end
    end

    // high halves sit one limb up; the top limb never carries for legal scales
    always_comb
    begin
        sum_item_next.ctl   = mul_ctl_reg;
        sum_item_next.rem   = mul_rem_reg;
        sum_item_next.y_mag = mul_y_reg;
        sum_item_next.x_mag = mul_lo_reg + {mul_hi_reg[HI_TOP:0], {LIMB_W{1'b0}}};
    end

    // sum stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && sum_ready)
        begin
            sum_item_reg <= sum_item_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_item  = sum_item_reg;

endmodule

// ===== src/sdc_compare.sv =====
// ----------------------------------------------------------------------------
// sdc_compare
// Final stage: exact magnitude compare, sign rules with signed zeros equal,
// and selection of the requested relation into the output register.
// ----------------------------------------------------------------------------
module sdc_compare
    import sdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output logic  holds
);

    logic [MAG_W-1:0] y_wide;
    logic             x_gt;
    logic             x_lt;
    logic             a_gt_mag;
    logic             a_lt_mag;
    logic             both_zero;
    logic             rel_lt;
    logic             rel_gt;
    logic             rel_eq;
    logic             holds_next;
    logic             valid_reg;
    logic             holds_reg;

    // magnitude compare, mapped back to a versus b
    always_comb
    begin
        y_wide    = MAG_W'(in_item.y_mag);
        x_gt      = in_item.x_mag > y_wide;
        x_lt      = in_item.x_mag < y_wide;
        a_gt_mag  = in_item.ctl.swap ? x_lt : x_gt;
        a_lt_mag  = in_item.ctl.swap ? x_gt : x_lt;
        both_zero = (in_item.x_mag == '0) && (in_item.y_mag == '0);
    end

    // sign rules
    always_comb
    begin
        rel_lt = 1'b0;
        rel_gt = 1'b0;
        priority if (both_zero)
        begin
            rel_lt = 1'b0;
            rel_gt = 1'b0;
        end
        else if (in_item.ctl.a_neg != in_item.ctl.b_neg)
        begin
            rel_lt = in_item.ctl.a_neg;
            rel_gt = !in_item.ctl.a_neg;
        end
        else if (in_item.ctl.a_neg)
        begin
            rel_lt = a_gt_mag;
            rel_gt = a_lt_mag;
        end
        else
        begin
            rel_lt = a_lt_mag;
            rel_gt = a_gt_mag;
        end
        rel_eq = !rel_lt && !rel_gt;
    end

    // relation select; unused codes give zero
    always_comb
    begin
        unique case (in_item.ctl.func)
            FUNC_EQ: holds_next = rel_eq;
            FUNC_NE: holds_next = !rel_eq;
            FUNC_LT: holds_next = rel_lt;
            FUNC_LE: holds_next = rel_lt || rel_eq;
            FUNC_GT: holds_next = rel_gt;
            FUNC_GE: holds_next = rel_gt || rel_eq;
            default: holds_next = 1'b0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            holds_reg <= holds_next;
        end
    end

    assign out_valid = valid_reg;
    assign holds     = holds_reg;

endmodule
